// ----- sv/scp_pkg.sv -----
// shared types and constants for the scan chain pattern detector
`timescale 1ns / 1ps
package scp_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int PAT_W       = MAX_PATTERN;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int ITER_W      = 8;
    localparam int CNT_W       = 8;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(MAX_PATTERN);
    localparam logic [ITER_W-1:0] ITER_RESET = 8'd128;
    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_BITS    = 2'd0,
        REG_PATTERN_LENGTH  = 2'd1,
        REG_ITERATION_COUNT = 2'd2,
        REG_NONE            = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OUT_RUNNING = 2'd0,
        OUT_MATCHED = 2'd1,
        OUT_ACTIVE  = 2'd2,
        OUT_SILENT  = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern_bits;
        logic [LEN_W-1:0]  pattern_length;
        logic [ITER_W-1:0] iteration_count;
    } t_cfg;

    typedef struct packed {
        logic             drive_bit;
        t_outcome         outcome;
        logic [CNT_W-1:0] register_length;
        logic [CNT_W-1:0] toggle_count;
    } t_result;

endpackage

// ----- sv/scp_cfg.sv -----
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
module scp_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scp_pkg::ADDR_W-1:0] paddr,
    input  logic [scp_pkg::DATA_W-1:0] pwdata,
    output logic [scp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output scp_pkg::t_cfg              o_cfg
);
    import scp_pkg::*;

    logic [PAT_W-1:0]  r_pattern_bits;
    logic [LEN_W-1:0]  r_pattern_length;
    logic [ITER_W-1:0] r_iteration_count;
    t_reg_idx          w_idx;
    logic              w_write;

    assign pready  = 1'b1;
    assign w_idx   = t_reg_idx'(paddr[4:3]);
    assign w_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bits    <= '0;
            r_pattern_length  <= LEN_RESET;
            r_iteration_count <= ITER_RESET;
        end else if (w_write) begin
            unique case (w_idx)
                REG_PATTERN_BITS:    r_pattern_bits    <= pwdata[PAT_W-1:0];
                REG_PATTERN_LENGTH:  r_pattern_length  <= pwdata[LEN_W-1:0];
                REG_ITERATION_COUNT: r_iteration_count <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PATTERN_BITS:    prdata = DATA_W'(r_pattern_bits);
            REG_PATTERN_LENGTH:  prdata = DATA_W'(r_pattern_length);
            REG_ITERATION_COUNT: prdata = DATA_W'(r_iteration_count);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.pattern_bits    = r_pattern_bits;
    assign o_cfg.pattern_length  = r_pattern_length;
    assign o_cfg.iteration_count = r_iteration_count;

endmodule

// ----- sv/scp_core.sv -----
// test state registers and the combinational sample update
`timescale 1ns / 1ps
module scp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_start_test,
    input  logic             i_sample_bit,
    input  scp_pkg::t_cfg    i_cfg,
    output scp_pkg::t_result o_result
);
    import scp_pkg::*;

    logic [PAT_W-1:0] r_window, n_window;
    logic [IDX_W-1:0] r_drive_idx, n_drive_idx;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0] r_toggles, n_toggles;
    logic             r_prev, n_prev;
    t_outcome         r_final, n_final;

    logic [LEN_W-1:0] w_len;
    logic [PAT_W-1:0] w_mask;
    logic [PAT_W-1:0] w_win_shift;
    logic [IDX_W-1:0] w_idx_base;
    logic [LEN_W-1:0] w_idx_inc;
    logic [IDX_W-1:0] w_idx_adv;
    logic             w_pat_bit;
    logic             w_drive;

    // effective length clamped to 1..MAX_PATTERN
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_len = LEN_W'(1);
        end else if (i_cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = i_cfg.pattern_length;
        end
    end

    assign w_mask = (w_len >= LEN_W'(MAX_PATTERN)) ? '1
                  : ((PAT_W'(1) << w_len[IDX_W-1:0]) - PAT_W'(1));

    assign w_win_shift = ((r_window >> 1)
                         | (PAT_W'(i_sample_bit) << IDX_W'(w_len - LEN_W'(1))))
                         & w_mask;

    // stale index after a length change restarts from bit 0
    assign w_idx_base = (i_start_test || ({1'b0, r_drive_idx} >= w_len))
                      ? '0 : r_drive_idx;
    assign w_pat_bit  = i_cfg.pattern_bits[w_idx_base];
    assign w_idx_inc  = {1'b0, w_idx_base} + LEN_W'(1);
    assign w_idx_adv  = (w_idx_inc >= w_len) ? '0 : w_idx_inc[IDX_W-1:0];

    always_comb begin
        n_window    = r_window;
        n_drive_idx = r_drive_idx;
        n_seen      = r_seen;
        n_toggles   = r_toggles;
        n_prev      = r_prev;
        n_final     = r_final;
        w_drive     = 1'b0;
        if (i_start_test) begin
            n_window    = '0;
            n_drive_idx = '0;
            n_seen      = '0;
            n_toggles   = '0;
            n_prev      = i_sample_bit;
            if (i_cfg.iteration_count == '0) begin
                n_final = OUT_SILENT;
            end else begin
                n_final     = OUT_RUNNING;
                w_drive     = w_pat_bit;
                n_drive_idx = w_idx_adv;
            end
        end else if (r_final == OUT_RUNNING) begin
            if ((i_sample_bit != r_prev) && (r_toggles != CNT_MAX)) begin
                n_toggles = r_toggles + CNT_W'(1);
            end
            n_prev   = i_sample_bit;
            n_window = w_win_shift;
            if (r_seen != CNT_MAX) begin
                n_seen = r_seen + CNT_W'(1);
            end
            if ((n_seen >= CNT_W'(w_len))
                && (((w_win_shift ^ i_cfg.pattern_bits) & w_mask) == '0)) begin
                n_final = OUT_MATCHED;
            end else if (n_seen >= i_cfg.iteration_count) begin
                n_final = (n_toggles > CNT_W'(1)) ? OUT_ACTIVE : OUT_SILENT;
            end else begin
                w_drive     = w_pat_bit;
                n_drive_idx = w_idx_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_drive_idx <= '0;
            r_seen      <= '0;
            r_toggles   <= '0;
            r_prev      <= 1'b0;
            r_final     <= OUT_RUNNING;
        end else if (i_accept) begin
            r_window    <= n_window;
            r_drive_idx <= n_drive_idx;
            r_seen      <= n_seen;
            r_toggles   <= n_toggles;
            r_prev      <= n_prev;
            r_final     <= n_final;
        end
    end

    assign o_result.drive_bit       = w_drive;
    assign o_result.outcome         = n_final;
    assign o_result.register_length =
        ((n_final == OUT_MATCHED) && (n_seen >= CNT_W'(w_len)))
        ? (n_seen - CNT_W'(w_len)) : '0;
    assign o_result.toggle_count    = n_toggles;

endmodule

// ----- sv/scan_chain_pattern_detector.sv -----
// top level: config registers, test state and result register
//
// Usage: each request on the input channel (i_in_valid / o_in_stall) is one
// bit read back from a scan chain. A request with i_start_test high restarts
// the test and records the baseline level. Every request yields exactly
// one result on the output channel (o_out_valid / i_out_stall): the next bit
// to drive into the chain, the outcome (running, matched, active, silent),
// the detected register length and the toggle count.
// The result of a request accepted at a clock edge is valid after that edge.
// Throughput is one request per cycle while the receiver does not stall;
// the state update and the window compare for a request are combinational
// logic between the test state registers and the result register.
// When the receiver stalls, the result register holds and o_in_stall rises
// while it is full, so no request is taken until the result is taken; a
// request is accepted in the same cycle that the held result leaves.
// Reset clears the test state (running, empty window, counters zero) and
// loads pattern_bits 0, pattern_length 64, iteration_count 128.
// Configuration is written through the apb-style port (byte offsets 0, 8,
// 16); the user writes it only while no request is in flight, unenforced.
`timescale 1ns / 1ps
module scan_chain_pattern_detector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scp_pkg::ADDR_W-1:0] paddr,
    input  logic [scp_pkg::DATA_W-1:0] pwdata,
    output logic [scp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_start_test,
    input  logic                       i_sample_bit,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_drive_bit,
    output logic [1:0]                 o_outcome,
    output logic [scp_pkg::CNT_W-1:0]  o_register_length,
    output logic [scp_pkg::CNT_W-1:0]  o_toggle_count
);
    import scp_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_accept;

    scp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_start_test (i_start_test),
        .i_sample_bit (i_sample_bit),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_bit       = r_result.drive_bit;
    assign o_outcome         = r_result.outcome;
    assign o_register_length = r_result.register_length;
    assign o_toggle_count    = r_result.toggle_count;

    a_len_only_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome != OUT_MATCHED)) |-> (o_register_length == '0))
        else $error("register length set without a match");

    a_drive_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome != OUT_RUNNING)) |-> !o_drive_bit)
        else $error("drive bit set after the test ended");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty result register");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no result");

endmodule

// ----- tb/scan_chain_pattern_detector_test.sv -----
// self-checking testbench for the scan chain pattern detector
`timescale 1ns / 1ps
module scan_chain_pattern_detector_test;
    import scp_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 3_000_000;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_KNOWN,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        start;
        logic        level;
        t_result     want;
        t_reg_idx    sel;
        logic [63:0] value;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_start_test;
    logic                i_sample_bit;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_drive_bit;
    logic [1:0]          o_outcome;
    logic [CNT_W-1:0]    o_register_length;
    logic [CNT_W-1:0]    o_toggle_count;

    // predictor copy of the registers and test state
    t_cfg                cfg;
    logic [PAT_W-1:0]    win_bits;
    int unsigned         drive_pos;
    logic [CNT_W-1:0]    seen_cnt;
    logic [CNT_W-1:0]    flip_cnt;
    logic                last_level;
    t_outcome            test_state;

    t_result             expected_results[$];
    t_result             head;
    t_row                directed_rows[$];
    logic                chain_bits[$];

    int                  error_count;
    int                  sent_count;
    int                  rand_items;
    int                  results_checked;
    int                  matched_seen;
    int                  active_seen;
    int                  silent_seen;
    int                  burst_left;

    int                  hold_left;
    int                  span_left;
    int                  stall_mode;
    bit                  hold_off_req;

    t_result             got;
    logic                level;
    int unsigned         eff;
    int unsigned         delay_bits;
    int unsigned         n_samples;
    int unsigned         flavor;
    logic [63:0]         pat_val;
    logic [LEN_W-1:0]    len_val;
    logic [ITER_W-1:0]   iter_val;

    scan_chain_pattern_detector u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_start_test      (i_start_test),
        .i_sample_bit      (i_sample_bit),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_drive_bit       (o_drive_bit),
        .o_outcome         (o_outcome),
        .o_register_length (o_register_length),
        .o_toggle_count    (o_toggle_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // cyclic pattern pointer, out-of-range index wraps to 0
    function automatic logic next_pattern_bit(input int unsigned len);
        int unsigned idx;
        logic        bit_out;
        idx = drive_pos;
        if (idx >= len) idx = 0;
        bit_out = cfg.pattern_bits[idx];
        idx++;
        if (idx >= len) idx = 0;
        drive_pos = idx;
        return bit_out;
    endfunction

    function automatic t_result detector_step(input logic start, input logic lvl);
        int unsigned      len;
        logic [PAT_W-1:0] mask;
        t_result          r;
        if (cfg.pattern_length == 0) len = 1;
        else if (cfg.pattern_length > MAX_PATTERN) len = MAX_PATTERN;
        else len = cfg.pattern_length;
        mask = (len >= 64) ? {64{1'b1}} : (64'd1 << len) - 64'd1;
        r.drive_bit       = 1'b0;
        r.register_length = '0;
        if (start) begin
            win_bits   = '0;
            drive_pos  = 0;
            seen_cnt   = '0;
            flip_cnt   = '0;
            last_level = lvl;
            test_state = (cfg.iteration_count == 0) ? OUT_SILENT : OUT_RUNNING;
            if (test_state == OUT_RUNNING) r.drive_bit = next_pattern_bit(len);
        end else if (test_state == OUT_RUNNING) begin
            if (lvl != last_level && flip_cnt != CNT_MAX) flip_cnt++;
            last_level = lvl;
            // newest sample enters at the top of the window
            win_bits = ((win_bits >> 1) | (64'(lvl) << (len - 1))) & mask;
            if (seen_cnt != CNT_MAX) seen_cnt++;
            if (seen_cnt >= len && ((win_bits ^ cfg.pattern_bits) & mask) == '0)
                test_state = OUT_MATCHED;
            else if (seen_cnt >= cfg.iteration_count)
                test_state = (flip_cnt > 1) ? OUT_ACTIVE : OUT_SILENT;
            else
                r.drive_bit = next_pattern_bit(len);
        end
        if (test_state == OUT_MATCHED && seen_cnt >= len)
            r.register_length = CNT_W'(seen_cnt - len);
        r.outcome      = test_state;
        r.toggle_count = flip_cnt;
        return r;
    endfunction

    function automatic t_row req_row(input logic start, input logic lvl);
        t_row row;
        row       = '0;
        row.kind  = ROW_PREDICTED;
        row.start = start;
        row.level = lvl;
        return row;
    endfunction

    function automatic t_row known_row(input logic start, input logic lvl, input logic drv,
                                       input t_outcome oc, input logic [7:0] reglen,
                                       input logic [7:0] toggles);
        t_row row;
        row                      = '0;
        row.kind                 = ROW_KNOWN;
        row.start                = start;
        row.level                = lvl;
        row.want.drive_bit       = drv;
        row.want.outcome         = oc;
        row.want.register_length = reglen;
        row.want.toggle_count    = toggles;
        return row;
    endfunction

    function automatic t_row write_row(input t_reg_idx sel, input logic [63:0] value);
        t_row row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.sel   = sel;
        row.value = value;
        return row;
    endfunction

    // offers one request, with bursts and random gaps, and records its expected result
    task automatic offer_sample(input logic start, input logic lvl, input logic has_want,
                                input t_result want, output t_result pred);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            i_in_valid   <= 1'b0;
            i_start_test <= 1'($urandom_range(0, 1));
            i_sample_bit <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_start_test <= start;
        i_sample_bit <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        pred = detector_step(start, lvl);
        expected_results.push_back(has_want ? want : pred);
        sent_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx sel, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            REG_PATTERN_BITS:    cfg.pattern_bits    = value;
            REG_PATTERN_LENGTH:  cfg.pattern_length  = value[LEN_W-1:0];
            REG_ITERATION_COUNT: cfg.iteration_count = value[ITER_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        hold_left  = 0;
        span_left  = 0;
        stall_mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (span_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                span_left  = $urandom_range(5, 60);
            end
            span_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= 1'($urandom_range(0, 1));
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no request waiting");
                error_count++;
            end else begin
                head = expected_results.pop_front();
                results_checked++;
                if (o_drive_bit !== head.drive_bit) begin
                    $error("drive_bit: expected %0d, got %0d", head.drive_bit, o_drive_bit);
                    error_count++;
                end
                if (o_outcome !== head.outcome) begin
                    $error("outcome: expected %0d, got %0d", head.outcome, o_outcome);
                    error_count++;
                end
                if (o_register_length !== head.register_length) begin
                    $error("register_length: expected %0d, got %0d",
                           head.register_length, o_register_length);
                    error_count++;
                end
                if (o_toggle_count !== head.toggle_count) begin
                    $error("toggle_count: expected %0d, got %0d",
                           head.toggle_count, o_toggle_count);
                    error_count++;
                end
                if (o_outcome == OUT_MATCHED) matched_seen++;
                if (o_outcome == OUT_ACTIVE) active_seen++;
                if (o_outcome == OUT_SILENT) silent_seen++;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_in_valid   <= 1'b0;
        i_start_test <= 1'b0;
        i_sample_bit <= 1'b0;
        hold_off_req    = 1'b0;
        error_count     = 0;
        sent_count      = 0;
        rand_items      = 0;
        results_checked = 0;
        matched_seen    = 0;
        active_seen     = 0;
        silent_seen     = 0;
        burst_left      = 0;
        cfg.pattern_bits    = '0;
        cfg.pattern_length  = LEN_RESET;
        cfg.iteration_count = ITER_RESET;
        win_bits   = '0;
        drive_pos  = 0;
        seen_cnt   = '0;
        flip_cnt   = '0;
        last_level = 1'b0;
        test_state = OUT_RUNNING;

        // sample without start after reset, baseline level 0
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0, OUT_RUNNING, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b1, 1'b0, OUT_RUNNING, 8'd0, 8'd1));
        directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0, OUT_RUNNING, 8'd0, 8'd0));
        // one-bit pattern, match on first sample, then a finished test
        directed_rows.push_back(write_row(REG_PATTERN_BITS, 64'd1));
        directed_rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd1));
        directed_rows.push_back(known_row(1'b1, 1'b0, 1'b1, OUT_RUNNING, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b1, 1'b0, OUT_MATCHED, 8'd0, 8'd1));
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0, OUT_MATCHED, 8'd0, 8'd1));
        // length zero acts as one
        directed_rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd0));
        directed_rows.push_back(known_row(1'b1, 1'b0, 1'b1, OUT_RUNNING, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b1, OUT_RUNNING, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b1, 1'b0, OUT_MATCHED, 8'd1, 8'd1));
        // zero budget ends the test at start
        directed_rows.push_back(write_row(REG_ITERATION_COUNT, 64'd0));
        directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0, OUT_SILENT, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0, OUT_SILENT, 8'd0, 8'd0));
        directed_rows.push_back(write_row(REG_ITERATION_COUNT, 64'd1));
        directed_rows.push_back(known_row(1'b1, 1'b0, 1'b1, OUT_RUNNING, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0, OUT_SILENT, 8'd0, 8'd0));
        // length above the maximum clamps to 64, budget runs out with toggles
        directed_rows.push_back(write_row(REG_PATTERN_BITS, {64{1'b1}}));
        directed_rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd127));
        directed_rows.push_back(write_row(REG_ITERATION_COUNT, 64'd3));
        directed_rows.push_back(known_row(1'b1, 1'b1, 1'b1, OUT_RUNNING, 8'd0, 8'd0));
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b1, OUT_RUNNING, 8'd0, 8'd1));
        directed_rows.push_back(known_row(1'b0, 1'b1, 1'b1, OUT_RUNNING, 8'd0, 8'd2));
        directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0, OUT_ACTIVE, 8'd0, 8'd3));
        // shrink the length mid-test so the drive pointer lies past it
        directed_rows.push_back(write_row(REG_PATTERN_BITS, 64'h5555_5555_5555_5555));
        directed_rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd64));
        directed_rows.push_back(write_row(REG_ITERATION_COUNT, 64'd255));
        directed_rows.push_back(req_row(1'b1, 1'b0));
        directed_rows.push_back(req_row(1'b0, 1'b1));
        directed_rows.push_back(req_row(1'b0, 1'b1));
        directed_rows.push_back(req_row(1'b0, 1'b0));
        directed_rows.push_back(req_row(1'b0, 1'b1));
        directed_rows.push_back(req_row(1'b0, 1'b0));
        directed_rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd4));
        directed_rows.push_back(req_row(1'b0, 1'b1));
        directed_rows.push_back(req_row(1'b0, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WRITE: begin
                    drain_results();
                    write_reg(directed_rows[i].sel, directed_rows[i].value);
                end
                ROW_KNOWN: offer_sample(directed_rows[i].start, directed_rows[i].level, 1'b1,
                                        directed_rows[i].want, got);
                default:   offer_sample(directed_rows[i].start, directed_rows[i].level, 1'b0,
                                        '0, got);
            endcase
        end

        // full-budget alternating run: counters reach their top, receiver holds off
        drain_results();
        write_reg(REG_PATTERN_BITS, 64'd0);
        write_reg(REG_PATTERN_LENGTH, 64'd64);
        write_reg(REG_ITERATION_COUNT, 64'd255);
        hold_off_req = 1'b1;
        level = 1'b0;
        offer_sample(1'b1, level, 1'b0, '0, got);
        repeat (258) begin
            level = ~level;
            offer_sample(1'b0, level, 1'b0, '0, got);
            rand_items++;
        end

        while (rand_items < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       pat_val = '0;
                1:       pat_val = {64{1'b1}};
                default: pat_val = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 15))
                0:       len_val = '0;
                1:       len_val = 7'd64;
                2:       len_val = 7'($urandom_range(65, 127));
                3:       len_val = 7'($urandom_range(13, 63));
                default: len_val = 7'($urandom_range(1, 12));
            endcase
            if (len_val == 0) eff = 1;
            else if (len_val > MAX_PATTERN) eff = MAX_PATTERN;
            else eff = len_val;
            case ($urandom_range(0, 9))
                0:       iter_val = '0;
                1:       iter_val = 8'd255;
                2:       iter_val = 8'd1;
                default: iter_val = 8'($urandom_range(eff, (eff + 24 > 255) ? 255 : eff + 24));
            endcase
            write_reg(REG_PATTERN_BITS, pat_val);
            write_reg(REG_PATTERN_LENGTH, 64'(len_val));
            write_reg(REG_ITERATION_COUNT, 64'(iter_val));

            repeat ((eff > 32) ? 1 : $urandom_range(1, 4)) begin
                // emulated chain: each sample is the bit driven delay_bits samples earlier
                delay_bits = $urandom_range(0, 12);
                flavor     = $urandom_range(0, 9);
                n_samples  = delay_bits + eff + $urandom_range(0, 4);
                chain_bits.delete();
                repeat (delay_bits) chain_bits.push_back(1'($urandom_range(0, 1)));
                if (flavor != 9) begin
                    offer_sample(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0, got);
                    chain_bits.push_back(got.drive_bit);
                    rand_items++;
                end
                repeat (n_samples) begin
                    if (flavor == 8 || chain_bits.size() == 0)
                        level = 1'($urandom_range(0, 1));
                    else
                        level = chain_bits.pop_front();
                    // corrupted chain now and then
                    if (flavor == 7 && $urandom_range(0, 7) == 0) level = ~level;
                    offer_sample(1'b0, level, 1'b0, '0, got);
                    chain_bits.push_back(got.drive_bit);
                    rand_items++;
                end
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("run covered %0d requests and %0d checked results", sent_count,
                 results_checked);
        $display("outcomes seen: %0d matched, %0d active, %0d silent", matched_seen,
                 active_seen, silent_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/scp_pkg.sv
sv/scp_cfg.sv
sv/scp_core.sv
sv/scan_chain_pattern_detector.sv
tb/scan_chain_pattern_detector_test.sv
